/* rtl/core/fbrf_pkg.sv */
package fbrf_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 128;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int RB_W        = $clog2(ROW_BYTES + 1);

  // Field widths
  localparam int COORD_W = 10;
  localparam int BCOL_W  = COORD_W - 3;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 7;
  localparam int PIX_W   = 8;

  // Action codes
  localparam logic ACT_FILL = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DATA,
    ST_FILL_RD,
    ST_FILL_WR
  } fbrf_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } fbrf_mem_req_t;

endpackage

/* rtl/core/fbrf_if.sv */
interface fbrf_in_if;
  import fbrf_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] corner_a_x;
  logic [COORD_W-1:0] corner_a_y;
  logic [COORD_W-1:0] corner_b_x;
  logic [COORD_W-1:0] corner_b_y;
  logic               ink;
  logic [COL_W-1:0]   read_byte_column;
  logic [ROW_W-1:0]   read_row;

  modport source (
    output valid, action, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           ink, read_byte_column, read_row,
    input  ready
  );
  modport sink (
    input  valid, action, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           ink, read_byte_column, read_row,
    output ready
  );
endinterface

interface fbrf_out_if;
  import fbrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;

  modport source (output valid, pixel_byte, input ready);
  modport sink (input valid, pixel_byte, output ready);
endinterface

/* rtl/core/fbrf_store.sv */
module fbrf_store (
  input  logic                   clk,
  input  fbrf_pkg::fbrf_mem_req_t req,
  output logic [7:0]             rd_data
);
  import fbrf_pkg::*;

  logic [PIX_W-1:0] mem [STORE_BYTES];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/mono_framebuffer_rect_fill_top.sv */
// Channel  Dir  Handshake        Payload
// in_bus   in   valid/ready      action, corner_a_x/y, corner_b_x/y, ink,
//                                read_byte_column, read_row
// out_bus  out  valid/ready      pixel_byte (one beat per read item)
//
// Reset: rst_n low starts a clearing pass over all STORE_BYTES bytes (2048 at
//   128x128) that writes zero to every byte; in_bus.ready stays low until done.
// Read item: store read, then the result sits in an output register (loaded once
//   an older beat drains), so a new item is taken while it waits on out_bus.ready.
// Fill item: ST_FILL_RD then ST_FILL_WR for each byte touched (read, then masked
//   write through the single store port), over rows * byte columns bytes.
// A clipped-away fill returns to idle at once and produces no beat.
module mono_framebuffer_rect_fill_top (
  input  logic       clk,
  input  logic       rst_n,
  fbrf_in_if.sink    in_bus,
  fbrf_out_if.source out_bus
);
  import fbrf_pkg::*;

  localparam int PROD_W = COORD_W + RB_W;
  localparam int FS_W   = ADDR_W + BCOL_W;

  fbrf_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_data_r, out_data_nxt;

  // Fill walk registers
  logic [BCOL_W-1:0]  bx0_r, bx0_nxt;
  logic [BCOL_W-1:0]  bx1_r, bx1_nxt;
  logic [BCOL_W-1:0]  bc_r, bc_nxt;
  logic [2:0]         lo_bit_r, lo_bit_nxt;
  logic [2:0]         hi_bit_r, hi_bit_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [COORD_W-1:0] y1_r, y1_nxt;
  logic [ADDR_W-1:0]  row_base_r, row_base_nxt;
  logic               ink_r, ink_nxt;
  logic               rd_zero_r, rd_zero_nxt;

  fbrf_mem_req_t      mem_req;
  logic [PIX_W-1:0]   mem_rd;

  // Corner sort and clip
  logic [COORD_W-1:0] xl, xh, yl, yh, xh_c, yh_c;
  logic               fill_skip;
  logic [PROD_W-1:0]  fill_prod;
  logic [PROD_W-1:0]  rd_prod;
  logic               rd_in_range;
  logic [ADDR_W-1:0]  rd_addr;
  logic [FS_W-1:0]    fill_sum;
  logic [ADDR_W-1:0]  fill_addr;
  logic [2:0]         m_lo, m_hi;
  logic [PIX_W-1:0]   fill_mask;

  fbrf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  always_comb begin
    if (in_bus.corner_a_x < in_bus.corner_b_x) begin
      xl = in_bus.corner_a_x;
      xh = in_bus.corner_b_x;
    end else begin
      xl = in_bus.corner_b_x;
      xh = in_bus.corner_a_x;
    end
    if (in_bus.corner_a_y < in_bus.corner_b_y) begin
      yl = in_bus.corner_a_y;
      yh = in_bus.corner_b_y;
    end else begin
      yl = in_bus.corner_b_y;
      yh = in_bus.corner_a_y;
    end
    fill_skip = (xl >= COORD_W'(PANEL_WIDTH)) || (yl >= COORD_W'(PANEL_HEIGHT));
    xh_c = (xh > COORD_W'(PANEL_WIDTH - 1))  ? COORD_W'(PANEL_WIDTH - 1)  : xh;
    yh_c = (yh > COORD_W'(PANEL_HEIGHT - 1)) ? COORD_W'(PANEL_HEIGHT - 1) : yh;
    fill_prod = yl * RB_W'(ROW_BYTES);
  end

  // Read address: row * ROW_BYTES + byte column
  always_comb begin
    rd_in_range = (COORD_W'(in_bus.read_byte_column) < COORD_W'(ROW_BYTES)) &&
                  (COORD_W'(in_bus.read_row) < COORD_W'(PANEL_HEIGHT));
    rd_prod     = PROD_W'(in_bus.read_row) * RB_W'(ROW_BYTES)
                + PROD_W'(in_bus.read_byte_column);
    rd_addr     = ADDR_W'(rd_prod);
  end

  // Fill byte address and edge masks
  always_comb begin
    fill_sum  = FS_W'(row_base_r) + FS_W'(bc_r);
    fill_addr = fill_sum[ADDR_W-1:0];
    m_lo      = (bc_r == bx0_r) ? lo_bit_r : 3'd0;
    m_hi      = (bc_r == bx1_r) ? hi_bit_r : 3'd7;
    fill_mask = (8'hFF << m_lo) & (8'hFF >> (3'd7 - m_hi));
  end

  assign in_bus.ready       = (state_r == ST_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.pixel_byte = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    bx0_nxt       = bx0_r;
    bx1_nxt       = bx1_r;
    bc_nxt        = bc_r;
    lo_bit_nxt    = lo_bit_r;
    hi_bit_nxt    = hi_bit_r;
    y_nxt         = y_r;
    y1_nxt        = y1_r;
    row_base_nxt  = row_base_r;
    ink_nxt       = ink_r;
    rd_zero_nxt   = rd_zero_r;
    mem_req       = '0;

    // output slot drains on its own
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt_r;
        mem_req.wdata = '0;
        if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_bus.valid) begin
          if (in_bus.action == ACT_READ) begin
            rd_zero_nxt  = !rd_in_range;
            mem_req.re   = rd_in_range;
            mem_req.addr = rd_addr;
            state_nxt    = ST_RD_DATA;
          end else if (!fill_skip) begin
            bx0_nxt      = xl[COORD_W-1:3];
            bx1_nxt      = xh_c[COORD_W-1:3];
            bc_nxt       = xl[COORD_W-1:3];
            lo_bit_nxt   = xl[2:0];
            hi_bit_nxt   = xh_c[2:0];
            y_nxt        = yl;
            y1_nxt       = yh_c;
            row_base_nxt = ADDR_W'(fill_prod);
            ink_nxt      = in_bus.ink;
            state_nxt    = ST_FILL_RD;
          end
        end
      end

      ST_RD_DATA: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_zero_r ? '0 : mem_rd;
          state_nxt     = ST_IDLE;
        end
      end

      ST_FILL_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = fill_addr;
        state_nxt    = ST_FILL_WR;
      end

      ST_FILL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = fill_addr;
        mem_req.wdata = ink_r ? (mem_rd | fill_mask) : (mem_rd & ~fill_mask);
        state_nxt     = ST_FILL_RD;
        if (bc_r == bx1_r) begin
          if (y_r == y1_r) begin
            state_nxt = ST_IDLE;
          end else begin
            y_nxt        = y_r + 1'b1;
            row_base_nxt = row_base_r + ADDR_W'(ROW_BYTES);
            bc_nxt       = bx0_r;
          end
        end else begin
          bc_nxt = bc_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    bx0_r      <= bx0_nxt;
    bx1_r      <= bx1_nxt;
    bc_r       <= bc_nxt;
    lo_bit_r   <= lo_bit_nxt;
    hi_bit_r   <= hi_bit_nxt;
    y_r        <= y_nxt;
    y1_r       <= y1_nxt;
    row_base_r <= row_base_nxt;
    ink_r      <= ink_nxt;
    rd_zero_r  <= rd_zero_nxt;
  end

endmodule

/* rtl/core/fbrf_checker.sv */
module fbrf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready
);
  import fbrf_pkg::*;

  logic rd_acc;
  assign rd_acc = in_valid && in_ready && (in_action == ACT_READ);

  // clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> !in_ready)
    else $error("ready high while read in flight");

  a_beat_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rd_acc, 2))
    else $error("out beat without a read two cycles earlier");

endmodule

bind mono_framebuffer_rect_fill_top fbrf_checker u_fbrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_action (in_bus.action),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready)
);
